>>> sv/page_swap_buffer_controller_assert.svh
// ----------------------------------------------------------------------------
// Page swap buffer controller assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef PAGE_SWAP_BUFFER_CONTROLLER_ASSERT_SVH
`define PAGE_SWAP_BUFFER_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define PSB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property on every clock edge, reset included
`define PSB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PSB_ASSERT(label, prop, msg)
`define PSB_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> sv/psb_pkg.sv
// ----------------------------------------------------------------------------
// psb_pkg
// Shared types and constants of the page swap buffer controller.
// ----------------------------------------------------------------------------
package psb_pkg;

  localparam int ADDR_W    = 16;
  localparam int ACTION_W  = 2;
  localparam int CMD_W     = 3;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 24;

  localparam logic [ADDR_W-1:0] BASE_RESET = 16'h4400;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_COMMIT = 2'd2
  } action_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_RAM_TO_BUF  = 3'd0,
    CMD_BUF_TO_RAM  = 3'd1,
    CMD_HOME_TO_RAM = 3'd2,
    CMD_BUF_TO_HOME = 3'd3,
    CMD_ERROR       = 3'd4
  } command_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SAVE,
    ST_FETCH,
    ST_SCAN,
    ST_ERROR
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_save;
    logic emit_fetch;
    logic emit_error;
    logic emit_scan;
    logic scan_step;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic item_err;
    logic item_commit;
    logic need_save;
    logic scan_marked;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> sv/psb_ctrl.sv
// ----------------------------------------------------------------------------
// psb_ctrl
// Sequencing state machine: accept, divide, save, fetch, commit scan, error.
// ----------------------------------------------------------------------------
module psb_ctrl
  import psb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (status.item_err) begin
            state_next = ST_ERROR;
          end else if (status.item_commit) begin
            state_next = ST_SAVE;
          end else begin
            state_next = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        state_next = status.need_save ? ST_SAVE : ST_FETCH;
      end
      ST_SAVE: begin
        if (status.out_free) begin
          state_next = status.item_commit ? ST_SCAN : ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (status.scan_marked && status.out_free && status.scan_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_ERROR: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // item_err and item_commit are decoded from the live input while idle
  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_DIVIDE: cmd.div_step   = 1'b1;
      ST_SAVE:   cmd.emit_save  = status.out_free;
      ST_FETCH:  cmd.emit_fetch = status.out_free;
      ST_ERROR:  cmd.emit_error = status.out_free;
      ST_SCAN: begin
        cmd.emit_scan = status.scan_marked && status.out_free;
        cmd.scan_step = !status.scan_marked || status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> sv/psb_datapath.sv
// ----------------------------------------------------------------------------
// psb_datapath
// Page state, base register, page index compare, commit scan and result
// register.
// ----------------------------------------------------------------------------
module psb_datapath
  import psb_pkg::*;
#(
  parameter int NUM_PAGES  = 8,
  parameter int PAGE_BYTES = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           status,
  input  logic                 cfg_we,
  input  logic [ADDR_W-1:0]    cfg_wdata,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 m_tready,
  output logic                 m_tvalid,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tlast
);

  localparam int IDX_W  = $clog2(NUM_PAGES);
  localparam int SPAN   = NUM_PAGES * PAGE_BYTES;
  localparam int SPAN_W = $clog2(SPAN + 1);
  localparam int CMP_W  = (SPAN_W > ADDR_W) ? SPAN_W : ADDR_W;
  localparam logic [ADDR_W-1:0] PAGE_SIZE = ADDR_W'(PAGE_BYTES);

  logic [ADDR_W-1:0]    base_address;
  logic [IDX_W-1:0]     current_page;
  logic                 dirty;
  logic [NUM_PAGES-1:0] in_buffer;

  logic [ACTION_W-1:0]  item_action;
  logic                 item_err;
  logic [ADDR_W-1:0]    rem;
  logic [IDX_W-1:0]     quotient;
  logic [IDX_W-1:0]     scan_idx;

  logic [CMD_W-1:0]     out_cmd;
  logic [ADDR_W-1:0]    out_addr;

  // input decode
  logic [ACTION_W-1:0]  in_action;
  logic [ADDR_W-1:0]    in_addr;
  logic [ADDR_W-1:0]    in_diff;
  logic                 in_commit;
  logic                 in_swap;
  logic                 in_err;

  assign in_action = s_tdata[ACTION_W-1:0];
  assign in_addr   = s_tdata[ACTION_W +: ADDR_W];
  assign in_diff   = in_addr - base_address;
  assign in_commit = (in_action == ACT_COMMIT);
  assign in_swap   = (in_action == ACT_READ) || (in_action == ACT_WRITE);
  assign in_err    = !in_commit && (!in_swap || (in_addr < base_address) ||
                                    (CMP_W'(in_diff) >= CMP_W'(SPAN)));

  // page index of the held offset: highest page boundary at or below it
  logic [IDX_W-1:0]     page_idx;

  always_comb begin
    page_idx = '0;
    for (int k = 1; k < NUM_PAGES; k++) begin
      if (CMP_W'(rem) >= CMP_W'(k * PAGE_BYTES)) begin
        page_idx = IDX_W'(k);
      end
    end
  end

  // commit scan: mark under the scan index and any mark above it
  logic [NUM_PAGES-1:0] marks_from;
  assign marks_from = in_buffer >> scan_idx;

  always_comb begin
    status.item_err    = cmd.load ? in_err : item_err;
    status.item_commit = cmd.load ? in_commit : (item_action == ACT_COMMIT);
    status.need_save   = (item_action == ACT_READ) || dirty;
    status.scan_marked = marks_from[0];
    status.scan_last   = ((marks_from >> 1) == '0);
    status.out_free    = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= BASE_RESET;
    end else if (cfg_we) begin
      base_address <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_page <= '0;
      dirty        <= 1'b0;
      in_buffer    <= '0;
    end else begin
      if (cmd.emit_save) begin
        in_buffer <= in_buffer | (NUM_PAGES'(1) << current_page);
      end
      if (cmd.emit_fetch) begin
        current_page <= quotient;
        if (item_action == ACT_WRITE) begin
          dirty <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_action <= in_action;
      item_err    <= in_err;
      rem         <= in_diff;
      scan_idx    <= '0;
    end else begin
      if (cmd.div_step) begin
        quotient <= page_idx;
      end
      if (cmd.scan_step) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  logic [IDX_W-1:0]  page_sel;
  logic [ADDR_W-1:0] page_home;

  always_comb begin
    page_sel = current_page;
    if (cmd.emit_fetch) begin
      page_sel = quotient;
    end else if (cmd.emit_scan) begin
      page_sel = scan_idx;
    end
  end

  assign page_home = base_address + ADDR_W'(page_sel) * PAGE_SIZE;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_save || cmd.emit_fetch || cmd.emit_error || cmd.emit_scan) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_error) begin
      out_cmd  <= CMD_ERROR;
      out_addr <= '0;
      m_tlast  <= 1'b1;
    end else if (cmd.emit_save) begin
      out_cmd  <= CMD_RAM_TO_BUF;
      out_addr <= page_home;
      m_tlast  <= 1'b0;
    end else if (cmd.emit_fetch) begin
      out_cmd  <= in_buffer[quotient] ? CMD_BUF_TO_RAM : CMD_HOME_TO_RAM;
      out_addr <= page_home;
      m_tlast  <= 1'b1;
    end else if (cmd.emit_scan) begin
      out_cmd  <= CMD_BUF_TO_HOME;
      out_addr <= page_home;
      m_tlast  <= status.scan_last;
    end
  end

  assign m_tdata = {{(M_TDATA_W - ADDR_W - CMD_W){1'b0}}, out_addr, out_cmd};

endmodule

>>> sv/page_swap_buffer_controller.sv
// ----------------------------------------------------------------------------
// page_swap_buffer_controller
// Copy-command sequencer for one RAM page window over buffered NV pages.
// ----------------------------------------------------------------------------
// One item is taken at a time; s_tready is high only between items. The
// steps per item, from the input transfer to loading the last result into
// the output register: a read or write swap runs the transfer, a step that
// compares the held page offset against every page boundary at once, the
// save when one is needed and the fetch; a commit runs the transfer, the
// save and the scan over the in-buffer marks up to the highest buffered
// page, one page per cycle unless a buffered page waits on a stalled output;
// an error runs the transfer and the error command. The result register
// holds a finished command while the next one is formed, so a stalled sink
// only pauses the sequence. base_address may be written only between items.
module page_swap_buffer_controller
  import psb_pkg::*;
#(
  parameter int NUM_PAGES  = 8,
  parameter int PAGE_BYTES = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration: base_address
  input  logic                 cfg_we,
  input  logic [ADDR_W-1:0]    cfg_wdata,
  // request stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [1:0] action, [17:2] address
  // copy command stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [2:0] command, [18:3] page_address
  output logic                 m_tlast    // final command of the request
);

`include "page_swap_buffer_controller_assert.svh"

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // state machine: decides which step runs each cycle
  psb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // page state, index compare, scan and the result register
  psb_datapath #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // command code on the output and whether a new result loads this cycle
  logic [CMD_W-1:0] out_code;
  logic             out_closing;
  logic             out_load;

  assign out_code    = m_tdata[CMD_W-1:0];
  assign out_closing = (out_code == CMD_ERROR) || (out_code == CMD_BUF_TO_RAM) ||
                       (out_code == CMD_HOME_TO_RAM);
  assign out_load    = cmd.emit_save || cmd.emit_fetch || cmd.emit_error || cmd.emit_scan;

  // Errors and fetches always close a request
  `PSB_ASSERT(a_close_cmd, m_tvalid && out_closing |-> m_tlast, "error or fetch without last")
  // A save is always followed by a fetch or a write-back
  `PSB_ASSERT(a_save_not_last, m_tvalid && (out_code == CMD_RAM_TO_BUF) |-> !m_tlast, "save marked last")
  // Never load a new result over one that is still stalled
  `PSB_ASSERT(a_no_overwrite, m_tvalid && !m_tready |-> !out_load, "result overwritten")
  // Nothing is presented right after reset
  `PSB_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !m_tvalid, "output valid after reset")

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: page swap buffer controller testbench
// Streams read swaps, write swaps, commits and malformed requests into the
// controller under several base addresses. Predicts every copy command from
// a local model of the page window, checks each command transfer field by
// field, and applies random and long back-pressure on the command stream.
// ----------------------------------------------------------------------------
module tb_top;
  import psb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PAGES  = 8;
  localparam int PAGE_BYTES = 1024;
  // Watchdog limit, with plenty of margin over the worst run.
  localparam int CYCLE_LIMIT = 400000;
  // Sink hold-off long enough to back the controller up into its input.
  localparam int LONG_HOLD   = 300;
  // Settle time before a base write.
  localparam int SETTLE      = 16;

  // Action code outside the defined set; the controller must reject it.
  localparam logic [ACTION_W-1:0] ACT_UNDEFINED = 2'd3;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [ADDR_W-1:0]   addr;
  } request_t;

  typedef struct {
    command_t          command;
    logic [ADDR_W-1:0] page_addr;
    logic              last;
  } copy_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [ADDR_W-1:0]    cfg_wdata;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // [1:0] action, [17:2] address
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // [2:0] command, [18:3] page_address
  logic                 m_tlast;

  page_swap_buffer_controller #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_BYTES(PAGE_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Requests waiting for the driver, and copy commands waiting for the sink.
  request_t pending_requests[$];
  copy_t    expected_copies[$];

  // Local picture of the page window.
  logic [ADDR_W-1:0]    win_base;
  int unsigned          cur_page;
  bit                   page_dirty;
  bit [NUM_PAGES-1:0]   buffered;

  // Traffic shaping.
  bit          steady;          // no idling on either side
  int          long_hold_req;
  int          long_hold_done;
  int          src_gap;
  int          sink_wait;
  logic        req_taken;
  request_t    drv_req;

  // Bookkeeping.
  int          fail_count;
  int          cycle_count;
  int          requests_sent;
  int          commits_sent;
  int          rejects_sent;
  int          copies_checked;
  int          base_settings;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Home address of a page under the current base, wrapping at 64 KiB.
  function automatic logic [ADDR_W-1:0] home_addr(int unsigned pg);
    logic [31:0] full;
    full = win_base + pg * PAGE_BYTES;
    return full[ADDR_W-1:0];
  endfunction

  // Work out the copy commands one request causes and advance the window.
  function automatic void plan_copies(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] addr);
    copy_t plan [NUM_PAGES+1];
    int          n;
    int unsigned pg;
    bit          ok;
    n  = 0;
    pg = 0;
    ok = 1'b1;
    requests_sent++;
    // Swaps must land inside the window; the address of a commit is ignored.
    if (act == ACT_UNDEFINED) begin
      ok = 1'b0;
    end else if (act != ACT_COMMIT) begin
      if (addr < win_base) begin
        ok = 1'b0;
      end else begin
        pg = (addr - win_base) / PAGE_BYTES;
        if (pg >= NUM_PAGES) ok = 1'b0;
      end
    end

    if (!ok) begin
      // Rejected: one error command, no change of state.
      plan[0] = '{CMD_ERROR, '0, 1'b0};
      n = 1;
      rejects_sent++;
    end else if (act == ACT_COMMIT) begin
      // Save the current page, then flush every buffered page home in order.
      plan[n] = '{CMD_RAM_TO_BUF, home_addr(cur_page), 1'b0};
      n = n + 1;
      buffered[cur_page] = 1'b1;
      for (int i = 0; i < NUM_PAGES; i++) begin
        if (buffered[i]) begin
          plan[n] = '{CMD_BUF_TO_HOME, home_addr(i), 1'b0};
          n = n + 1;
        end
      end
      commits_sent++;
    end else begin
      // A read swap always saves; a write swap saves only a dirty page.
      if (act == ACT_READ || page_dirty) begin
        plan[n] = '{CMD_RAM_TO_BUF, home_addr(cur_page), 1'b0};
        n = n + 1;
        buffered[cur_page] = 1'b1;
      end
      // Fetch from the buffer if the mark is set after the save, else from home.
      if (buffered[pg]) plan[n] = '{CMD_BUF_TO_RAM, home_addr(pg), 1'b0};
      else              plan[n] = '{CMD_HOME_TO_RAM, home_addr(pg), 1'b0};
      n = n + 1;
      cur_page = pg;
      if (act == ACT_WRITE) page_dirty = 1'b1;
    end

    plan[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_copies.push_back(plan[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void queue_req(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] addr);
    request_t r;
    r.act  = act;
    r.addr = addr;
    pending_requests.push_back(r);
  endfunction

  // Mostly well-formed swaps into the window, with commits, window edges,
  // stray addresses and undefined actions mixed in.
  function automatic void queue_random_req();
    int          pick;
    logic [31:0] a;
    logic [ACTION_W-1:0] act;
    pick = $urandom_range(0, 99);
    act  = ($urandom_range(0, 1) == 0) ? ACT_READ : ACT_WRITE;
    if (pick < 9) begin
      queue_req(ACT_COMMIT, ADDR_W'($urandom_range(0, 16'hFFFF)));
    end else if (pick < 13) begin
      queue_req(ACT_UNDEFINED, ADDR_W'($urandom_range(0, 16'hFFFF)));
    end else if (pick < 21) begin
      queue_req(act, ADDR_W'($urandom_range(0, 16'hFFFF)));
    end else if (pick < 28) begin
      // Just outside or on the boundaries of the window.
      case ($urandom_range(0, 3))
        0:       a = win_base - 1;
        1:       a = win_base;
        2:       a = win_base + NUM_PAGES * PAGE_BYTES - 1;
        default: a = win_base + NUM_PAGES * PAGE_BYTES;
      endcase
      queue_req(act, a[ADDR_W-1:0]);
    end else begin
      a = win_base + $urandom_range(0, NUM_PAGES - 1) * PAGE_BYTES
          + $urandom_range(0, PAGE_BYTES - 1);
      queue_req(act, a[ADDR_W-1:0]);
    end
  endfunction

  // Block until no request is in flight and every command has been seen.
  task automatic wait_idle();
    while (!(pending_requests.size() == 0 && !s_tvalid && expected_copies.size() == 0))
      @(posedge clk);
  endtask

  // Rewrite the base register between phases, once the block has settled.
  task automatic set_base(logic [ADDR_W-1:0] value);
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    win_base = value;
    base_settings++;
  endtask

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d commands still expected",
               cycle_count, expected_copies.size());
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request driver: changes its outputs at the falling edge
  // --------------------------------------------------------------------------

  // Record each request transfer and predict its commands at the same edge.
  always @(posedge clk) begin
    req_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) plan_copies(s_tdata[1:0], s_tdata[17:2]);
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else if (!s_tvalid || req_taken) begin
      // Bus is free: idle out a gap, else offer the next request.
      if (src_gap > 0) begin
        src_gap  = src_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        drv_req = pending_requests.pop_front();
        s_tdata  <= {{(S_TDATA_W - ADDR_W - ACTION_W){1'b0}}, drv_req.addr, drv_req.act};
        s_tvalid <= 1'b1;
        if (!steady && $urandom_range(0, 4) == 0) src_gap = $urandom_range(1, 10);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command sink: back-pressure at the falling edge
  // --------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (long_hold_done != long_hold_req) begin
      // Start a long hold-off; the sender keeps offering meanwhile.
      long_hold_done = long_hold_req;
      sink_wait      = LONG_HOLD - 1;
      m_tready       <= 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait = sink_wait - 1;
      m_tready  <= 1'b0;
    end else if (!steady && $urandom_range(0, 7) == 0) begin
      // Start a random stall burst.
      sink_wait = $urandom_range(0, 9);
      m_tready  <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check every command transfer against the oldest expectation
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    copy_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_copies.size() == 0) begin
        $error("unexpected command transfer: command %0d page_address 0x%04h last %0b",
               m_tdata[2:0], m_tdata[18:3], m_tlast);
        fail_count++;
      end else begin
        want = expected_copies.pop_front();
        copies_checked++;
        if (m_tdata[2:0] !== want.command) begin
          $error("command: expected %0d, got %0d", want.command, m_tdata[2:0]);
          fail_count++;
        end
        if (m_tdata[18:3] !== want.page_addr) begin
          $error("page_address: expected 0x%04h, got 0x%04h", want.page_addr, m_tdata[18:3]);
          fail_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b0;
    req_taken      = 1'b0;
    steady         = 1'b0;
    long_hold_req  = 0;
    long_hold_done = 0;
    src_gap        = 0;
    sink_wait      = 0;
    fail_count     = 0;
    cycle_count    = 0;
    requests_sent  = 0;
    commits_sent   = 0;
    rejects_sent   = 0;
    copies_checked = 0;
    base_settings  = 0;
    win_base       = BASE_RESET;
    cur_page       = 0;
    page_dirty     = 1'b0;
    buffered       = '0;

    // Hold reset, then release it at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset base, fresh state.
    queue_req(ACT_COMMIT, 16'h0000);        // commit with nothing buffered yet
    queue_req(ACT_READ, 16'h4400);          // first byte of page 0, now buffered
    queue_req(ACT_READ, 16'h5FFF);          // last byte of page 6
    queue_req(ACT_WRITE, 16'h4800);         // clean write swap: no save
    queue_req(ACT_WRITE, 16'h4C00);         // dirty write swap: save first
    queue_req(ACT_READ, 16'h4BFF);          // buffered page comes back from buffer
    queue_req(ACT_READ, 16'h43FF);          // below base
    queue_req(ACT_WRITE, 16'h6000);         // first byte of the last page
    queue_req(ACT_READ, 16'h0000);
    queue_req(ACT_WRITE, 16'hFFFF);
    queue_req(ACT_UNDEFINED, 16'h4400);     // undefined action
    queue_req(ACT_UNDEFINED, 16'hFFFF);
    queue_req(ACT_WRITE, 16'h5C00);
    queue_req(ACT_COMMIT, 16'hFFFF);        // long flush
    queue_req(ACT_READ, 16'h5000);
    queue_req(ACT_COMMIT, 16'h4400);

    // Directed: base at zero.
    set_base(16'h0000);
    queue_req(ACT_READ, 16'h0000);
    queue_req(ACT_WRITE, 16'h1FFF);
    queue_req(ACT_READ, 16'h2000);          // past the last page
    queue_req(ACT_COMMIT, 16'h1234);

    // Directed: base at the top, homes of higher pages wrap around.
    set_base(16'hFFFF);
    queue_req(ACT_READ, 16'hFFFF);
    queue_req(ACT_WRITE, 16'hFFFE);         // below base
    queue_req(ACT_COMMIT, 16'h0000);

    // Random, reset base, with one long sink hold-off.
    set_base(BASE_RESET);
    repeat (100) queue_random_req();
    long_hold_req++;

    // Random, arbitrary base low enough for a full window.
    set_base(ADDR_W'($urandom_range(0, 16'hE000)));
    repeat (80) queue_random_req();

    // Random, base near the top: half the window wraps past 64 KiB.
    set_base(16'hF000);
    repeat (50) queue_random_req();

    // Random, any base, no idling on either side.
    set_base(ADDR_W'($urandom_range(0, 16'hFFFF)));
    wait_idle();
    steady = 1'b1;
    repeat (70) queue_random_req();

    // Drain, then wait on for any stray commands.
    wait_idle();
    repeat (SETTLE * 2) @(posedge clk);
    if (expected_copies.size() != 0) begin
      $error("%0d expected commands never arrived", expected_copies.size());
      fail_count++;
    end

    $display("Run covered %0d requests (%0d commits, %0d rejected) under %0d base settings.",
             requests_sent, commits_sent, rejects_sent, base_settings);
    $display("Checked %0d copy commands, %0d mismatches.", copies_checked, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
